### src/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Sizes, command and status codes, controller states and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int BUCKETS    = 256;
	localparam int CAPACITY   = 256;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int BKT_W      = $clog2(BUCKETS);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int PTR_W      = IDX_W + 1;          // node index plus null
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

	localparam logic [2:0] CMD_FIND    = 3'd0;
	localparam logic [2:0] CMD_INSERT  = 3'd1;
	localparam logic [2:0] CMD_FIND_OR = 3'd2;
	localparam logic [2:0] CMD_REPLACE = 3'd3;
	localparam logic [2:0] CMD_REMOVE  = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EXISTS = 2'd1;
	localparam logic [1:0] ST_NOTFND = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,     // sweep bucket heads to null after reset
		S_IDLE,
		S_HEAD_RD,   // bucket head read issued
		S_HEAD_WT,
		S_NODE_RD,   // node read issued for cur
		S_NODE_WT,
		S_CHECK,     // compare key of cur
		S_FREE_RD,
		S_FREE_WT,
		S_APPLY,     // write stores
		S_OUT
	} chm_state_t;

	typedef struct packed {
		logic load;        // capture input word
		logic clr_wr;      // write NIL to bucket at clear pointer
		logic clr_inc;
		logic head_rd;
		logic head_cap;    // cur <= head data
		logic node_rd;
		logic node_cap;
		logic step;        // prev <= cur, cur <= next, steps++
		logic free_rd;
		logic do_insert;
		logic do_update;
		logic do_remove;
		logic set_result;  // compute result word
		logic out_load;
	} chm_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic cur_nil;
		logic key_hit;
		logic steps_done;
		logic pool_empty;
		logic [2:0] cmd;
		logic repl;
	} chm_sts_t;

endpackage

### src/chm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ctrl: command sequencer
// Clears bucket heads after reset, then walks one chain per command and
// drives the datapath updates.
// ----------------------------------------------------------------------------
module chm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_busy,   // output register full and stalled
	input  chm_pkg::chm_sts_t sts,
	output chm_pkg::chm_cmd_t cmd,
	output logic              present     // key found by the walk
);

	chm_pkg::chm_state_t state_q, state_nx;
	logic present_q, present_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= chm_pkg::S_CLEAR;
			present_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			present_q <= present_nx;
		end
	end

	assign present = present_q;

	always_comb begin
		logic need_add;
		need_add   = 1'b0;
		state_nx   = state_q;
		present_nx = present_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			chm_pkg::S_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.clr_inc = 1'b1;
				if (sts.clr_done) state_nx = chm_pkg::S_IDLE;
			end
			chm_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = chm_pkg::S_HEAD_RD;
				end
			end
			chm_pkg::S_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_nx = chm_pkg::S_HEAD_WT;
			end
			chm_pkg::S_HEAD_WT: begin
				cmd.head_cap = 1'b1;
				state_nx = chm_pkg::S_NODE_RD;
			end
			chm_pkg::S_NODE_RD: begin
				if (sts.cur_nil || sts.steps_done) begin
					present_nx = 1'b0;
					state_nx   = chm_pkg::S_FREE_RD;
				end else begin
					cmd.node_rd = 1'b1;
					state_nx = chm_pkg::S_NODE_WT;
				end
			end
			chm_pkg::S_NODE_WT: begin
				cmd.node_cap = 1'b1;
				state_nx = chm_pkg::S_CHECK;
			end
			chm_pkg::S_CHECK: begin
				if (sts.key_hit) begin
					present_nx = 1'b1;
					state_nx   = chm_pkg::S_FREE_RD;
				end else begin
					cmd.step = 1'b1;
					state_nx = chm_pkg::S_NODE_RD;
				end
			end
			chm_pkg::S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_nx = chm_pkg::S_FREE_WT;
			end
			chm_pkg::S_FREE_WT: state_nx = chm_pkg::S_APPLY;
			chm_pkg::S_APPLY: begin
				cmd.set_result = 1'b1;
				need_add = !present_q && !sts.pool_empty &&
					(sts.cmd == chm_pkg::CMD_INSERT || sts.cmd == chm_pkg::CMD_FIND_OR);
				cmd.do_insert = need_add;
				cmd.do_update = present_q &&
					((sts.cmd == chm_pkg::CMD_INSERT && sts.repl) ||
					 sts.cmd == chm_pkg::CMD_REPLACE);
				cmd.do_remove = present_q && sts.cmd == chm_pkg::CMD_REMOVE;
				state_nx = chm_pkg::S_OUT;
			end
			chm_pkg::S_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_nx = chm_pkg::S_IDLE;
				end
			end
			default: state_nx = chm_pkg::S_IDLE;
		endcase
	end

endmodule

### src/chm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_dp: hash map datapath
// Bucket heads, node stores and free stack memories, the walk registers
// and the result word.
// ----------------------------------------------------------------------------
module chm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  chm_pkg::chm_cmd_t               cmd,
	output chm_pkg::chm_sts_t               sts,
	input  logic [2:0]                      in_cmd,
	input  logic [chm_pkg::KEY_BITS-1:0]    in_key,
	input  logic [chm_pkg::VALUE_BITS-1:0]  in_value,
	input  logic                            in_repl,
	input  logic                            present,
	output logic [1:0]                      res_status,
	output logic [chm_pkg::VALUE_BITS-1:0]  res_value,
	output logic [chm_pkg::CNT_W-1:0]       res_count
);

	localparam int PW = chm_pkg::PTR_W;
	localparam int IW = chm_pkg::IDX_W;
	localparam int BW = chm_pkg::BKT_W;
	localparam int CW = chm_pkg::CNT_W;

	logic [PW-1:0]                  head_mem [chm_pkg::BUCKETS];
	logic [chm_pkg::KEY_BITS-1:0]   key_mem  [chm_pkg::CAPACITY];
	logic [chm_pkg::VALUE_BITS-1:0] val_mem  [chm_pkg::CAPACITY];
	logic [PW-1:0]                  next_mem [chm_pkg::CAPACITY];
	logic [IW-1:0]                  free_mem [chm_pkg::CAPACITY];

	logic [2:0]                     cmd_q;
	logic [chm_pkg::KEY_BITS-1:0]   key_q;
	logic [chm_pkg::VALUE_BITS-1:0] val_q;
	logic                           repl_q;
	logic [PW-1:0]                  head_rd_q, next_rd_q, cur_q, prev_q, nnext_q;
	logic [chm_pkg::KEY_BITS-1:0]   key_rd_q;
	logic [chm_pkg::VALUE_BITS-1:0] val_rd_q, nval_q;
	logic [IW-1:0]                  free_rd_q;
	logic [CW-1:0]                  steps_q, free_top_q, held_q;
	logic [BW:0]                    clr_q;   // one extra bit flags done
	logic [CW-1:0]                  low_q;   // lowest free stack slot ever popped

	wire [BW-1:0] bkt = key_q[BW-1:0];
	wire [CW-1:0] top_m1 = free_top_q - CW'(1);

	// free stack reset is identity: a slot popped for the first time reads as
	// its own index, later pops see the entry pushed since
	wire [IW-1:0] free_pop = (top_m1 < low_q) ? top_m1[IW-1:0] : free_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_cmd;
			key_q  <= in_key;
			val_q  <= in_value;
			repl_q <= in_repl;
		end
		if (cmd.clr_wr && !clr_q[BW])
			head_mem[clr_q[BW-1:0]] <= chm_pkg::NIL;
		if (cmd.head_rd) head_rd_q <= head_mem[bkt];
		if (cmd.node_rd) begin
			key_rd_q  <= key_mem[cur_q[IW-1:0]];
			val_rd_q  <= val_mem[cur_q[IW-1:0]];
			next_rd_q <= next_mem[cur_q[IW-1:0]];
		end
		if (cmd.free_rd) free_rd_q <= free_mem[top_m1[IW-1:0]];
		if (cmd.head_cap) begin
			cur_q  <= head_rd_q;
			prev_q <= chm_pkg::NIL;
		end
		if (cmd.node_cap) begin
			nnext_q <= next_rd_q;
			nval_q  <= val_rd_q;
		end
		if (cmd.step) begin
			prev_q <= cur_q;
			cur_q  <= nnext_q;
		end
		if (cmd.do_insert) begin
			key_mem[free_pop]  <= key_q;
			val_mem[free_pop]  <= val_q;
			next_mem[free_pop] <= head_rd_q;
			head_mem[bkt]      <= {1'b0, free_pop};
		end
		if (cmd.do_update) val_mem[cur_q[IW-1:0]] <= val_q;
		if (cmd.do_remove) begin
			if (prev_q != chm_pkg::NIL) next_mem[prev_q[IW-1:0]] <= nnext_q;
			else                        head_mem[bkt] <= nnext_q;
			free_mem[free_top_q[IW-1:0]] <= cur_q[IW-1:0];
		end
		if (cmd.set_result) begin
			res_status <= chm_pkg::ST_OK;
			res_value  <= present ? nval_q : '0;
			case (cmd_q)
				chm_pkg::CMD_INSERT: begin
					if (present) begin
						if (repl_q) res_value <= val_q;
						else        res_status <= chm_pkg::ST_EXISTS;
					end else if (free_top_q != '0) res_value <= val_q;
					else res_status <= chm_pkg::ST_FULL;
				end
				chm_pkg::CMD_FIND_OR: begin
					if (!present) begin
						if (free_top_q != '0) res_value <= val_q;
						else res_status <= chm_pkg::ST_FULL;
					end
				end
				chm_pkg::CMD_REPLACE: begin
					if (present) res_value <= val_q;
					else res_status <= chm_pkg::ST_NOTFND;
				end
				chm_pkg::CMD_REMOVE: begin
					res_value <= '0;
					if (!present) res_status <= chm_pkg::ST_NOTFND;
				end
				default: if (!present) res_status <= chm_pkg::ST_NOTFND;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			steps_q    <= '0;
			free_top_q <= CW'(chm_pkg::CAPACITY);
			held_q     <= '0;
			low_q      <= CW'(chm_pkg::CAPACITY);
		end else begin
			if (cmd.clr_inc && !clr_q[BW]) clr_q <= clr_q + (BW+1)'(1);
			if (cmd.head_cap) steps_q <= '0;
			if (cmd.step)     steps_q <= steps_q + CW'(1);
			if (cmd.do_insert) begin
				free_top_q <= top_m1;
				held_q     <= held_q + CW'(1);
				if (top_m1 < low_q) low_q <= top_m1;
			end
			if (cmd.do_remove) begin
				free_top_q <= free_top_q + CW'(1);
				held_q     <= held_q - CW'(1);
			end
		end
	end

	assign res_count = held_q;

	always_comb begin
		sts            = '0;
		sts.clr_done   = clr_q[BW];
		sts.cur_nil    = cur_q[PW-1];
		sts.key_hit    = key_rd_q == key_q;
		sts.steps_done = steps_q == CW'(chm_pkg::CAPACITY);
		sts.pool_empty = free_top_q == '0;
		sts.cmd        = cmd_q;
		sts.repl       = repl_q;
	end

endmodule

### src/chained_hash_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map: key-value map with separate chaining over a node pool
// Walk: the key's bucket head is read, then each chain node in turn until the
// key is found, the chain ends or the step limit is reached.
// Flow: one command at a time; the walk through the node memory and a stalled
// output register hold off the next word.
// Reset: a sweep nulls the bucket heads; input is stalled meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        replace_flag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] result_value,
	output logic [8:0]  entry_count
);

	chm_pkg::chm_cmd_t ctl;
	chm_pkg::chm_sts_t sts;
	logic [1:0]  r_status;
	logic [31:0] r_value;
	logic [8:0]  r_count;
	logic        present;

	chm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_busy (out_valid && out_stall),
		.sts      (sts),
		.cmd      (ctl),
		.present  (present)
	);

	chm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl),
		.sts        (sts),
		.in_cmd     (cmd),
		.in_key     (key),
		.in_value   (value),
		.in_repl    (replace_flag),
		.present    (present),
		.res_status (r_status),
		.res_value  (r_value),
		.res_count  (r_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)               out_valid <= 1'b0;
		else if (ctl.out_load)     out_valid <= 1'b1;
		else if (!out_stall)       out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status       <= r_status;
			found        <= present;
			result_value <= r_value;
			entry_count  <= r_count;
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for chained_hash_map
// Drives find/insert/find-or-insert/replace/remove and unused command codes in
// bursts, keeps a scoreboard map of key to value plus the node-pool count, and
// checks every result word field by field against the predicted answer.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] key;
		logic [31:0] value;
		logic        repl;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] value;
		logic [8:0]  count;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd = '0;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic        replace_flag = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        found;
	logic [31:0] result_value;
	logic [8:0]  entry_count;

	chained_hash_map uut (.*);

	always #2 clk = ~clk;

	cmd_word_t   cmd_q[$];
	answer_t     answer_q[$];
	logic [31:0] map_val[logic [31:0]];
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_full = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;
	longint      cycles = 0;
	logic        in_taken = 1'b0;   // input word accepted at the last rising edge
	logic [31:0] key_pool[$];

	// predict one answer and update the scoreboard map
	function automatic answer_t apply_cmd(cmd_word_t w);
		answer_t a;
		logic    hit;
		hit = map_val.exists(w.key);
		a.found = hit;
		a.status = chm_pkg::ST_OK;
		a.value = hit ? map_val[w.key] : '0;
		case (w.cmd)
			chm_pkg::CMD_INSERT, chm_pkg::CMD_FIND_OR: begin
				if (hit) begin
					if (w.cmd == chm_pkg::CMD_INSERT) begin
						if (w.repl) begin
							map_val[w.key] = w.value;
							a.value = w.value;
						end else
							a.status = chm_pkg::ST_EXISTS;
					end
				end else if (map_val.num() >= chm_pkg::CAPACITY) begin
					a.status = chm_pkg::ST_FULL;
					n_full++;
				end else begin
					map_val[w.key] = w.value;
					a.value = w.value;
				end
			end
			chm_pkg::CMD_REPLACE: begin
				if (hit) begin
					map_val[w.key] = w.value;
					a.value = w.value;
				end else
					a.status = chm_pkg::ST_NOTFND;
			end
			chm_pkg::CMD_REMOVE: begin
				if (hit) begin
					map_val.delete(w.key);
					a.value = '0;
				end else
					a.status = chm_pkg::ST_NOTFND;
			end
			default: if (!hit) a.status = chm_pkg::ST_NOTFND;
		endcase
		a.count = 9'(map_val.num());
		return a;
	endfunction

	function automatic cmd_word_t make_cmd(logic [2:0] c, logic [31:0] k,
			logic [31:0] v, logic r);
		cmd_word_t w;
		w.cmd = c;
		w.key = k;
		w.value = v;
		w.repl = r;
		return w;
	endfunction

	// keys mostly from a small pool sharing few buckets so chains get long
	function automatic logic [31:0] pick_key();
		if (key_pool.size() == 0 || $urandom_range(0, 7) == 0) begin
			logic [31:0] k;
			k = $urandom;
			if ($urandom_range(0, 1)) k[7:0] = 8'($urandom_range(0, 3));
			key_pool.push_back(k);
			return k;
		end
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_valid) n_sent++;
			if (cmd_q.size() > 0 && burst_left > 0) begin
				cmd_word_t w;
				w = cmd_q.pop_front();
				answer_q.push_back(apply_cmd(w));
				in_valid <= 1'b1;
				cmd <= w.cmd;
				key <= w.key;
				value <= w.value;
				replace_flag <= w.repl;
				burst_left <= burst_left - 1;
			end else begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				else begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
				end
			end
		end
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_taken <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected result word status=%0d value=%h", $time,
					status, result_value);
				errors++;
			end else begin
				answer_t e;
				e = answer_q.pop_front();
				n_checked++;
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (found !== e.found) begin
					$display("%0t: found exp %0d got %0d", $time, e.found, found);
					errors++;
				end
				if (result_value !== e.value) begin
					$display("%0t: result_value exp %h got %h", $time, e.value,
						result_value);
					errors++;
				end
				if (entry_count !== e.count) begin
					$display("%0t: entry_count exp %0d got %0d", $time, e.count,
						entry_count);
					errors++;
				end
			end
		end
		if (cycles > 2000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, every command, each special case
		cmd_q.push_back(make_cmd(chm_pkg::CMD_FIND, 32'h0, 32'h0, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REPLACE, 32'hFFFFFFFF, 32'h1, 1'b1));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'h0, 32'hFFFFFFFF, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'hFFFFFFFF, 32'h0, 1'b1));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'h0, 32'h1234, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'h0, 32'h5678, 1'b1));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_FIND_OR, 32'h0, 32'h9, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_FIND_OR, 32'h100, 32'hA5A5A5A5, 1'b1));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'h200, 32'h3, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REPLACE, 32'h100, 32'h5A5A5A5A, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_FIND, 32'h100, 32'h0, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REMOVE, 32'h100, 32'h0, 1'b0)); // mid chain
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REMOVE, 32'h200, 32'h0, 1'b0)); // chain head
		cmd_q.push_back(make_cmd(3'd5, 32'h0, 32'hFFFFFFFF, 1'b1));
		cmd_q.push_back(make_cmd(3'd6, 32'h1, 32'h0, 1'b0));
		cmd_q.push_back(make_cmd(3'd7, 32'hFFFFFFFF, 32'h0, 1'b1));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REMOVE, 32'h0, 32'h0, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_REMOVE, 32'hFFFFFFFF, 32'h0, 1'b0));
		// fill the pool, then hit the full case for both insert kinds
		for (int i = 0; i < chm_pkg::CAPACITY; i++)
			cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'(i * 37 + 5), $urandom,
				1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'hDEAD0000, 32'h1, 1'b0));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_FIND_OR, 32'hDEAD0001, 32'h1, 1'b1));
		cmd_q.push_back(make_cmd(chm_pkg::CMD_INSERT, 32'(5), 32'h7, 1'b1));
		for (int i = 0; i < chm_pkg::CAPACITY; i++)
			cmd_q.push_back(make_cmd(chm_pkg::CMD_REMOVE, 32'(i * 37 + 5), 32'h0, 1'b0));
		// random traffic, mostly on a reused key pool
		for (int i = 0; i < 1266; i++) begin
			k = pick_key();
			cmd_q.push_back(make_cmd(3'($urandom_range(0, 7)), k, $urandom,
				1'($urandom_range(0, 1))));
		end
		wait (cmd_q.size() == 0);
		@(posedge clk);
		while (in_valid) @(posedge clk);
		wait (answer_q.size() == 0);
		repeat (50) @(posedge clk);
		$display("Sent %0d command words and checked %0d result words.", n_sent,
			n_checked);
		$display("Saw %0d table-full answers; %0d keys held at the end.", n_full,
			map_val.num());
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
src/chm_pkg.sv
src/chm_ctrl.sv
src/chm_dp.sv
src/chained_hash_map.sv
verif/tb.sv
